>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the block cache tag engine.
// Included by modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/lbc_pkg.sv
// Shared types and constants of the LRU block cache tag engine.
// Depends on nothing; used by lru_block_cache_tags, which sizes its memories with it.
package lbc_pkg;

   localparam int KEY_W       = 40;
   localparam int DEVICE_W    = 8;
   localparam int SECTOR_W    = 16;
   localparam int BLOCK_W     = 16;
   localparam int SLOT_W      = 6;
   localparam int LIMIT_W     = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef logic [KEY_W-1:0] key_type;

endpackage

>>> rtl/lbc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; storage for the block cache tag engine.
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lru_block_cache_tags.sv
// Fully associative LRU tag and replacement engine for a block cache. Each operation
// (get or put of a device/sector/block key) returns one beat with hit, slot and evicted.
// The result beat is loaded once the scan is done and the result register is free of
// rsp_stall; the next request is accepted only when the engine is back in idle, after the
// rank sweep, or after the result beat is loaded on a get miss. Every line's key and recency
// rank is read once through the single read port of the key and rank memories to find the
// match or the least recent line; then, except on a get miss, the rank memory is swept
// again, one entry a cycle, to age the lines and make the chosen one most recent.
// Lines fill from slot 0 upward and are never dropped, so the line count alone marks which
// entries are valid and no clearing pass is needed after reset. The data array is
// outside this block; the slot output addresses it. Depends on lbc_pkg, lbc_ram and
// assert_macros.svh.
`include "assert_macros.svh"

module lru_block_cache_tags #(
   parameter int CAPACITY = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [lbc_pkg::DEVICE_W-1:0]    req_device_id,
   input  logic [lbc_pkg::SECTOR_W-1:0]    req_sector,
   input  logic [lbc_pkg::BLOCK_W-1:0]     req_block_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [lbc_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                            rsp_evicted,
   input  logic                            csr_wr_en,
   input  logic [lbc_pkg::LIMIT_W-1:0]     csr_wr_data
);

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > lbc_pkg::LIMIT_W) ? CW : lbc_pkg::LIMIT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [lbc_pkg::LIMIT_W-1:0]  limit_ff, limit_in;
   logic                         op_ff, op_in;
   lbc_pkg::key_type             key_ff, key_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [IW-1:0]                pend_idx_ff, pend_idx_in;
   logic                         found_ff, found_in;
   logic [IW-1:0]                hit_idx_ff, hit_idx_in;
   logic [IW-1:0]                hit_rank_ff, hit_rank_in;
   logic                         any_ff, any_in;
   logic [IW-1:0]                max_idx_ff, max_idx_in;
   logic [IW-1:0]                max_rank_ff, max_rank_in;
   logic [IW-1:0]                slot_ff, slot_in;
   logic [IW:0]                  thr_ff, thr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [lbc_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_evicted_ff, rsp_evicted_in;

   lbc_pkg::key_type             key_rd;
   logic [IW-1:0]                rank_rd;
   logic                         key_we;
   logic                         rank_we;
   logic [IW-1:0]                rank_wd;

   logic                         req_accept;
   logic                         issue;
   logic                         rsp_free;
   logic                         rsp_load;
   logic [CMPW-1:0]              eff_limit;
   logic                         full;
   logic [IW-1:0]                dec_slot;
   logic [IW:0]                  dec_thr;
   logic                         dec_hit;
   logic                         dec_evict;
   logic                         dec_fill;
   logic                         dec_upd;

   // Tag and recency storage.
   lbc_ram #(.WIDTH(lbc_pkg::KEY_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (dec_slot),
      .wr_data (key_ff),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (key_rd)
   );

   lbc_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (pend_idx_ff),
      .wr_data (rank_wd),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rank_rd)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign issue      = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) && (idx_ff < count_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == ST_DECIDE) && rsp_free;

   // A limit of zero acts as one; a limit above the capacity saturates.
   always_comb begin
      eff_limit = CMPW'(limit_ff);
      if (limit_ff == '0) begin
         eff_limit = CMPW'(1);
      end else if (CMPW'(limit_ff) > CMPW'(CAPACITY)) begin
         eff_limit = CMPW'(CAPACITY);
      end
   end

   assign full = (CMPW'(count_ff) >= eff_limit);

   // Outcome of the scan. A fill ages every line, so its threshold lies above any rank.
   always_comb begin
      dec_slot  = '0;
      dec_thr   = '0;
      dec_hit   = 1'b0;
      dec_evict = 1'b0;
      dec_fill  = 1'b0;
      dec_upd   = 1'b0;
      priority if (found_ff) begin
         dec_slot = hit_idx_ff;
         dec_thr  = {1'b0, hit_rank_ff};
         dec_hit  = 1'b1;
         dec_upd  = 1'b1;
      end else if (op_ff == lbc_pkg::OP_PUT && full) begin
         dec_slot  = max_idx_ff;
         dec_thr   = {1'b0, max_rank_ff};
         dec_evict = 1'b1;
         dec_upd   = 1'b1;
      end else if (op_ff == lbc_pkg::OP_PUT) begin
         dec_slot = count_ff[IW-1:0];
         dec_thr  = (IW + 1)'(CAPACITY);
         dec_fill = 1'b1;
         dec_upd  = 1'b1;
      end else begin
         dec_slot = '0;
      end
   end

   assign key_we  = rsp_load && (op_ff == lbc_pkg::OP_PUT) && !found_ff;
   assign rank_we = (state_ff == ST_UPDATE) && pend_ff;

   always_comb begin
      if (pend_idx_ff == slot_ff) begin
         rank_wd = '0;
      end else if ({1'b0, rank_rd} < thr_ff) begin
         rank_wd = rank_rd + IW'(1);
      end else begin
         rank_wd = rank_rd;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      limit_in       = csr_wr_en ? csr_wr_data : limit_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      idx_in         = issue ? idx_ff + CW'(1) : idx_ff;
      pend_in        = issue;
      pend_idx_in    = idx_ff[IW-1:0];
      found_in       = found_ff;
      hit_idx_in     = hit_idx_ff;
      hit_rank_in    = hit_rank_ff;
      any_in         = any_ff;
      max_idx_in     = max_idx_ff;
      max_rank_in    = max_rank_ff;
      slot_in        = slot_ff;
      thr_in         = thr_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_evicted_in = rsp_evicted_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_op;
               key_in   = {req_device_id, req_sector, req_block_number};
               idx_in   = '0;
               found_in = 1'b0;
               any_in   = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               // The first match wins; the victim is the lowest line of highest rank.
               if (key_rd == key_ff && !found_ff) begin
                  found_in    = 1'b1;
                  hit_idx_in  = pend_idx_ff;
                  hit_rank_in = rank_rd;
               end
               if (!any_ff || rank_rd > max_rank_ff) begin
                  any_in      = 1'b1;
                  max_idx_in  = pend_idx_ff;
                  max_rank_in = rank_rd;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = dec_hit;
               rsp_slot_in    = lbc_pkg::SLOT_W'(dec_slot);
               rsp_evicted_in = dec_evict;
               slot_in        = dec_slot;
               thr_in         = dec_thr;
               idx_in         = '0;
               if (dec_fill) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = dec_upd ? ST_UPDATE : ST_IDLE;
            end
         end
         ST_UPDATE: begin
            if (!issue && !pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= lbc_pkg::LIMIT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      idx_ff         <= idx_in;
      pend_idx_ff    <= pend_idx_in;
      found_ff       <= found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_rank_ff    <= hit_rank_in;
      any_ff         <= any_in;
      max_idx_ff     <= max_idx_in;
      max_rank_ff    <= max_rank_in;
      slot_ff        <= slot_in;
      thr_ff         <= thr_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_evicted = rsp_evicted_ff;

   `ASSERT_NEVER(a_count_in_range, clock, reset, count_ff > CW'(CAPACITY),
      "line count above capacity")
   `ASSERT_NEVER(a_hit_and_evict, clock, reset, rsp_valid && rsp_hit && rsp_evicted,
      "result beat flags both hit and eviction")
   `ASSERT_CLK(a_fill_counts, clock, reset,
      rsp_load && dec_fill |=> count_ff == $past(count_ff) + CW'(1),
      "fill did not advance the line count")
   `ASSERT_CLK(a_rank_write_in_use, clock, reset, rank_we |-> CW'(pend_idx_ff) < count_ff,
      "rank update outside the lines in use")

endmodule
